// ===== hw/rtl/utep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 text console cursor engine package
// Shared widths, codes, reset values and event types.
// ----------------------------------------------------------------------------
package utep_pkg;

    localparam int W_BYTE = 8;
    localparam int W_ROW  = 7;
    localparam int W_COL  = 8;
    localparam int W_CP   = 21;
    localparam int W_RGB  = 24;
    localparam int W_CCNT = 9;
    localparam int W_RCNT = 8;
    localparam int W_CIDX = 2;
    localparam int W_RCNT_RUN = 3;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_ROWS_DEF    = 128;

    localparam logic [W_CCNT-1:0] COLUMNS_RST = 9'd80;
    localparam logic [W_RCNT-1:0] ROWS_RST    = 8'd25;
    localparam logic [W_RGB-1:0]  FG_RST      = 24'hFFFFFF;
    localparam logic [W_RGB-1:0]  BG_RST      = 24'h000000;

    localparam logic [W_CP-1:0] CP_QMARK = 21'h00003F;
    localparam logic [W_CP-1:0] CP_SPACE = 21'h000020;
    localparam logic [W_CP-1:0] CP_MAX   = 21'h10FFFF;

    localparam logic [W_BYTE-1:0] B_BS    = 8'h08;
    localparam logic [W_BYTE-1:0] B_TAB   = 8'h09;
    localparam logic [W_BYTE-1:0] B_LF    = 8'h0A;
    localparam logic [W_BYTE-1:0] B_CR    = 8'h0D;
    localparam logic [W_BYTE-1:0] B_SPACE = 8'h20;
    localparam logic [W_BYTE-1:0] B_DEL   = 8'h7F;
    localparam logic [W_BYTE-1:0] B_HIGH  = 8'h80;

    typedef enum logic {
        EVT_WRITE  = 1'b0,
        EVT_SCROLL = 1'b1
    } t_evt_kind;

    typedef enum logic [W_CIDX-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_FG      = 2'd2,
        CFG_BG      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_evt_kind         kind;
        logic [W_ROW-1:0]  row;
        logic [W_COL-1:0]  col;
        logic [W_CP-1:0]   cp;
    } t_evt;

    typedef struct packed {
        logic [W_RCNT_RUN-1:0] cnt;
        t_evt [3:0]            evt;
    } t_run;

endpackage
`default_nettype wire

// ===== hw/rtl/utep_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 text console cursor engine channels
// Byte input, event output and register write channels.
// ----------------------------------------------------------------------------
interface utep_byte_if;
    logic                           valid;
    logic                           ready;
    logic [utep_pkg::W_BYTE-1:0]    in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utep_evt_if;
    logic                           valid;
    logic                           ready;
    logic                           event_kind;
    logic [utep_pkg::W_ROW-1:0]     cell_row;
    logic [utep_pkg::W_COL-1:0]     cell_column;
    logic [utep_pkg::W_CP-1:0]      codepoint;
    logic [utep_pkg::W_RGB-1:0]     cell_foreground;
    logic [utep_pkg::W_RGB-1:0]     cell_background;
    logic                           last_of_run;
    modport source (output valid, output event_kind, output cell_row, output cell_column,
                    output codepoint, output cell_foreground, output cell_background,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input cell_row, input cell_column,
                    input codepoint, input cell_foreground, input cell_background,
                    input last_of_run, output ready);
endinterface

interface utep_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [utep_pkg::W_CIDX-1:0]    index;
    logic [utep_pkg::W_RGB-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/utep_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 text console cursor engine register file
// Holds grid size and colors, limits grid size to the supported range.
// ----------------------------------------------------------------------------
module utep_cfg #(
    parameter int MAX_COLUMNS = utep_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = utep_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    utep_cfg_if.sink                                     i_cfg,
    output logic [$clog2(MAX_COLUMNS+1)-1:0]             o_eff_cols,
    output logic [$clog2(MAX_ROWS+1)-1:0]                o_eff_rows,
    output logic [utep_pkg::W_RGB-1:0]                   o_fg,
    output logic [utep_pkg::W_RGB-1:0]                   o_bg
);
    import utep_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS+1);
    localparam int ERW = $clog2(MAX_ROWS+1);

    logic [W_CCNT-1:0] r_cols;
    logic [W_RCNT-1:0] r_rows;
    logic [W_RGB-1:0]  r_fg;
    logic [W_RGB-1:0]  r_bg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLUMNS_RST;
            r_rows <= ROWS_RST;
            r_fg   <= FG_RST;
            r_bg   <= BG_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_COLUMNS: r_cols <= i_cfg.data[W_CCNT-1:0];
                CFG_ROWS:    r_rows <= i_cfg.data[W_RCNT-1:0];
                CFG_FG:      r_fg   <= i_cfg.data;
                CFG_BG:      r_bg   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cols == '0) begin
            o_eff_cols = CW'(1);
        end else if (32'(r_cols) > MAX_COLUMNS) begin
            o_eff_cols = CW'(MAX_COLUMNS);
        end else begin
            o_eff_cols = CW'(r_cols);
        end
        if (r_rows == '0) begin
            o_eff_rows = ERW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            o_eff_rows = ERW'(MAX_ROWS);
        end else begin
            o_eff_rows = ERW'(r_rows);
        end
    end

    assign o_fg = r_fg;
    assign o_bg = r_bg;

endmodule
`default_nettype wire

// ===== hw/rtl/utep_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 text console cursor engine step logic
// Decodes one byte against the cursor and decoder state, builds its events.
// ----------------------------------------------------------------------------
module utep_step #(
    parameter int MAX_COLUMNS = utep_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = utep_pkg::MAX_ROWS_DEF
) (
    input  wire logic [utep_pkg::W_BYTE-1:0]             i_byte,
    input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]        i_col,
    input  wire logic [$clog2(MAX_ROWS)-1:0]             i_row,
    input  wire logic [utep_pkg::W_CP-1:0]               i_partial,
    input  wire logic [1:0]                              i_cont,
    input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]        i_eff_cols,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0]           i_eff_rows,
    output logic [$clog2(MAX_COLUMNS+1)-1:0]             o_col,
    output logic [$clog2(MAX_ROWS)-1:0]                  o_row,
    output logic [utep_pkg::W_CP-1:0]                    o_partial,
    output logic [1:0]                                   o_cont,
    output utep_pkg::t_run                               o_run
);
    import utep_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS+1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int ERW = $clog2(MAX_ROWS+1);

    typedef struct packed {
        logic [CW-1:0]         col;
        logic [RW-1:0]         row;
        logic [W_RCNT_RUN-1:0] cnt;
        t_evt [3:0]            evt;
    } t_ctx;

    function automatic t_ctx emit(t_ctx c, t_evt_kind kind, logic [RW-1:0] row,
                                  logic [CW-1:0] col, logic [W_CP-1:0] cp);
        t_ctx r;
        r = c;
        r.evt[c.cnt[1:0]].kind = kind;
        r.evt[c.cnt[1:0]].row  = W_ROW'(row);
        r.evt[c.cnt[1:0]].col  = W_COL'(col);
        r.evt[c.cnt[1:0]].cp   = cp;
        r.cnt = c.cnt + 1'b1;
        return r;
    endfunction

    function automatic t_ctx next_line(t_ctx c, logic [ERW-1:0] rows);
        t_ctx r;
        logic [RW-1:0] bottom;
        r = c;
        bottom = RW'(rows - ERW'(1));
        r.col = '0;
        if (ERW'(c.row) + ERW'(1) >= rows) begin
            r = emit(r, EVT_SCROLL, bottom, '0, CP_SPACE);
            r.row = bottom;
        end else begin
            r.row = c.row + 1'b1;
        end
        return r;
    endfunction

    function automatic t_ctx put_char(t_ctx c, logic [W_CP-1:0] cp, logic [CW-1:0] cols,
                                      logic [ERW-1:0] rows);
        t_ctx r;
        r = c;
        if (c.col >= cols) begin
            r = next_line(r, rows);
        end
        r = emit(r, EVT_WRITE, r.row, r.col, cp);
        r.col = r.col + 1'b1;
        return r;
    endfunction

    t_ctx                ctx;
    logic                fresh;
    logic [CW+3:0]       tab;
    logic [W_CP-1:0]     acc;

    always_comb begin
        ctx       = '0;
        ctx.col   = (i_col > i_eff_cols) ? i_eff_cols : i_col;
        ctx.row   = (ERW'(i_row) >= i_eff_rows) ? RW'(i_eff_rows - ERW'(1)) : i_row;
        o_partial = i_partial;
        o_cont    = i_cont;
        fresh     = 1'b1;
        tab       = '0;
        acc       = {i_partial[W_CP-7:0], i_byte[5:0]};

        if (i_cont != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                o_cont = 2'd0;
                ctx    = put_char(ctx, CP_QMARK, i_eff_cols, i_eff_rows);
            end else begin
                fresh     = 1'b0;
                o_partial = acc;
                o_cont    = i_cont - 2'd1;
                if (i_cont == 2'd1) begin
                    ctx = put_char(ctx, (acc <= CP_MAX) ? acc : CP_QMARK,
                                   i_eff_cols, i_eff_rows);
                end
            end
        end

        if (fresh) begin
            if (i_byte < B_SPACE || i_byte == B_DEL) begin
                case (i_byte)
                    B_LF: ctx = next_line(ctx, i_eff_rows);
                    B_CR: ctx.col = '0;
                    B_BS: begin
                        if (ctx.col != '0) begin
                            ctx.col = ctx.col - 1'b1;
                        end
                    end
                    B_TAB: begin
                        tab = (CW+4)'(ctx.col) + (CW+4)'(8);
                        tab[2:0] = 3'b000;
                        if (tab >= (CW+4)'(i_eff_cols)) begin
                            ctx.col = i_eff_cols - 1'b1;
                        end else begin
                            ctx.col = CW'(tab);
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_byte < B_HIGH) begin
                ctx = put_char(ctx, W_CP'(i_byte), i_eff_cols, i_eff_rows);
            end else if (i_byte[7:5] == 3'b110) begin
                o_partial = W_CP'(i_byte[4:0]);
                o_cont    = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                o_partial = W_CP'(i_byte[3:0]);
                o_cont    = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                o_partial = W_CP'(i_byte[2:0]);
                o_cont    = 2'd3;
            end else begin
                ctx = put_char(ctx, CP_QMARK, i_eff_cols, i_eff_rows);
            end
        end

        o_col     = ctx.col;
        o_row     = ctx.row;
        o_run.cnt = ctx.cnt;
        o_run.evt = ctx.evt;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_text_console_cursor_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 text console cursor engine
// Decodes console bytes into cell writes and scroll events.
//
//   channel   role   handshake      word
//   i_byte    sink   valid/ready    in_byte
//   o_evt     source valid/ready    one cell write or scroll event
//   i_cfg     sink   valid/ready    register index and data
//
// A byte is decoded in the cycle it is accepted; its events are registered and leave one
// per cycle while o_evt.ready is high, so one byte per cycle with single-event bytes.
// A byte with n events holds the event stage until its last event is taken; one
// more byte's events wait in a second run register, after which i_byte.ready drops.
// Reset clears the cursor, decoder state and registers; no clearing pass.
// ----------------------------------------------------------------------------
module utf8_text_console_cursor_engine_unit #(
    parameter int MAX_COLUMNS = utep_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = utep_pkg::MAX_ROWS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    utep_byte_if.sink   i_byte,
    utep_evt_if.source  o_evt,
    utep_cfg_if.sink    i_cfg
);
    import utep_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS+1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int ERW = $clog2(MAX_ROWS+1);

    logic [CW-1:0]   eff_cols;
    logic [ERW-1:0]  eff_rows;
    logic [W_RGB-1:0] fg;
    logic [W_RGB-1:0] bg;

    logic [CW-1:0]   r_col,     n_col;
    logic [RW-1:0]   r_row,     n_row;
    logic [W_CP-1:0] r_partial, n_partial;
    logic [1:0]      r_cont,    n_cont;
    t_run            step_run;

    logic            r_out_v;
    t_run            r_out_run;
    logic [1:0]      r_out_idx;
    logic            r_pend_v;
    t_run            r_pend_run;

    logic            accept;
    logic            new_v;
    logic            last;
    logic            pop;
    logic            out_free;
    t_evt            cur;

    utep_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .o_eff_cols (eff_cols),
        .o_eff_rows (eff_rows),
        .o_fg       (fg),
        .o_bg       (bg)
    );

    utep_step #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_step (
        .i_byte     (i_byte.in_byte),
        .i_col      (r_col),
        .i_row      (r_row),
        .i_partial  (r_partial),
        .i_cont     (r_cont),
        .i_eff_cols (eff_cols),
        .i_eff_rows (eff_rows),
        .o_col      (n_col),
        .o_row      (n_row),
        .o_partial  (n_partial),
        .o_cont     (n_cont),
        .o_run      (step_run)
    );

    assign i_byte.ready = !r_pend_v;
    assign accept       = i_byte.valid && !r_pend_v;
    assign new_v        = accept && (step_run.cnt != '0);

    assign cur      = r_out_run.evt[r_out_idx];
    assign last     = ({1'b0, r_out_idx} + 3'd1) == r_out_run.cnt;
    assign pop      = r_out_v && o_evt.ready;
    assign out_free = !r_out_v || (pop && last);

    assign o_evt.valid           = r_out_v;
    assign o_evt.event_kind      = cur.kind;
    assign o_evt.cell_row        = cur.row;
    assign o_evt.cell_column     = cur.col;
    assign o_evt.codepoint       = cur.cp;
    assign o_evt.cell_foreground = fg;
    assign o_evt.cell_background = bg;
    assign o_evt.last_of_run     = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_partial <= '0;
            r_cont    <= '0;
        end else if (accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_partial <= n_partial;
            r_cont    <= n_cont;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_idx <= '0;
        end else if (out_free) begin
            r_out_idx <= '0;
            if (r_pend_v) begin
                r_out_v   <= 1'b1;
                r_out_run <= r_pend_run;
                r_pend_v  <= 1'b0;
            end else if (new_v) begin
                r_out_v   <= 1'b1;
                r_out_run <= step_run;
            end else begin
                r_out_v   <= 1'b0;
            end
        end else begin
            if (pop) begin
                r_out_idx <= r_out_idx + 2'd1;
            end
            if (new_v) begin
                r_pend_v   <= 1'b1;
                r_pend_run <= step_run;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_out_v)
        else $error("pending run without active run");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ({1'b0, r_out_idx} < r_out_run.cnt))
        else $error("event index beyond run length");

    a_stall_holds_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_evt.ready) |=> (r_out_v && $stable(r_out_idx)))
        else $error("event stage moved while stalled");

    a_cursor_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept) && $stable(eff_rows) |-> (ERW'(r_row) < eff_rows))
        else $error("cursor row outside grid");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_utf8_text_console_cursor_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 text console cursor engine testbench
// Streams directed and random console text into the engine over several grid
// sizes and colors, predicts every cell write and scroll event from a local
// model of the cursor and decoder, and checks each event word in order.
// ----------------------------------------------------------------------------
module tb_utf8_text_console_cursor_engine_unit;
    import utep_pkg::*;

    typedef struct packed {
        t_evt_kind          kind;
        logic [W_ROW-1:0]   row;
        logic [W_COL-1:0]   col;
        logic [W_CP-1:0]    cp;
        logic [W_RGB-1:0]   fg;
        logic [W_RGB-1:0]   bg;
        logic               last;
    } t_cell_evt;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   drv_valid   = 1'b0;
    logic [W_BYTE-1:0]      drv_byte    = '0;
    logic                   sink_ready  = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [W_CIDX-1:0]      cfg_index   = '0;
    logic [W_RGB-1:0]       cfg_data    = '0;

    bit                     byte_fire   = 1'b0;
    bit                     no_idle     = 1'b0;
    bit                     sink_hold   = 1'b0;
    event                   sink_stall_go;
    int                     bytes_queued = 0;
    int                     bytes_taken  = 0;
    int                     err_count    = 0;

    logic [W_BYTE-1:0]      text_bytes [$];
    t_cell_evt              cell_events_due [$];
    t_cell_evt              run_buf [4];
    int                     run_len;
    t_cell_evt              got_evt;
    t_cell_evt              want_evt;

    // model registers and state
    logic [W_CCNT-1:0]      grid_cols;
    logic [W_RCNT-1:0]      grid_rows;
    logic [W_RGB-1:0]       ink_fg;
    logic [W_RGB-1:0]       ink_bg;
    logic [W_CCNT-1:0]      cur_col;
    logic [W_ROW-1:0]       cur_row;
    logic [W_CP-1:0]        acc_cp;
    logic [1:0]             cont_left;
    int                     lim_cols;
    int                     lim_rows;

    utep_byte_if byte_bus ();
    utep_evt_if  evt_bus ();
    utep_cfg_if  cfg_bus ();

    assign byte_bus.valid   = drv_valid;
    assign byte_bus.in_byte = drv_byte;
    assign evt_bus.ready    = sink_ready;
    assign cfg_bus.valid    = cfg_valid;
    assign cfg_bus.index    = cfg_index;
    assign cfg_bus.data     = cfg_data;

    utf8_text_console_cursor_engine_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_bus),
        .o_evt   (evt_bus),
        .i_cfg   (cfg_bus)
    );

    always #6 clk = ~clk;

    task automatic push_event(t_evt_kind k, int r, int c, logic [W_CP-1:0] cp);
        if (run_len < 4) begin
            run_buf[run_len].kind = k;
            run_buf[run_len].row  = r[W_ROW-1:0];
            run_buf[run_len].col  = c[W_COL-1:0];
            run_buf[run_len].cp   = cp;
            run_buf[run_len].fg   = ink_fg;
            run_buf[run_len].bg   = ink_bg;
            run_buf[run_len].last = 1'b0;
            run_len++;
        end
    endtask

    task automatic advance_line();
        int nr;
        cur_col = '0;
        nr = int'(cur_row) + 1;
        if (nr >= lim_rows) begin
            push_event(EVT_SCROLL, lim_rows - 1, 0, CP_SPACE);
            nr = lim_rows - 1;
        end
        cur_row = nr[W_ROW-1:0];
    endtask

    task automatic place_glyph(logic [W_CP-1:0] cp);
        if (int'(cur_col) >= lim_cols)
            advance_line();
        push_event(EVT_WRITE, int'(cur_row), int'(cur_col), cp);
        cur_col = cur_col + 1'b1;
    endtask

    task automatic apply_control(logic [W_BYTE-1:0] b);
        int t;
        case (b)
            B_LF: advance_line();
            B_CR: cur_col = '0;
            B_BS: begin
                if (cur_col > 0)
                    cur_col = cur_col - 1'b1;
            end
            B_TAB: begin
                t = (int'(cur_col) + 8) & ~7;
                if (t >= lim_cols)
                    t = lim_cols - 1;
                cur_col = t[W_CCNT-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic decode_fresh(logic [W_BYTE-1:0] b);
        if (b < B_SPACE || b == B_DEL) begin
            apply_control(b);
        end else if (b < B_HIGH) begin
            place_glyph({13'd0, b});
        end else if ((b & 8'he0) == 8'hc0) begin
            acc_cp    = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end else if ((b & 8'hf0) == 8'he0) begin
            acc_cp    = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end else if ((b & 8'hf8) == 8'hf0) begin
            acc_cp    = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end else begin
            place_glyph(CP_QMARK);
        end
    endtask

    task automatic console_step(logic [W_BYTE-1:0] b);
        lim_cols = (grid_cols == 0) ? 1 : int'(grid_cols);
        if (lim_cols > MAX_COLUMNS_DEF)
            lim_cols = MAX_COLUMNS_DEF;
        lim_rows = (grid_rows == 0) ? 1 : int'(grid_rows);
        if (lim_rows > MAX_ROWS_DEF)
            lim_rows = MAX_ROWS_DEF;
        if (int'(cur_row) >= lim_rows)
            cur_row = W_ROW'(lim_rows - 1);
        if (int'(cur_col) > lim_cols)
            cur_col = W_CCNT'(lim_cols);
        run_len = 0;
        if (cont_left == 0) begin
            decode_fresh(b);
        end else if (b[7:6] != 2'b10) begin
            cont_left = 2'd0;
            place_glyph(CP_QMARK);
            decode_fresh(b);
        end else begin
            acc_cp    = {acc_cp[W_CP-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0)
                place_glyph((acc_cp <= CP_MAX) ? acc_cp : CP_QMARK);
        end
        if (run_len > 0)
            run_buf[run_len-1].last = 1'b1;
        for (int i = 0; i < run_len; i++)
            cell_events_due.push_back(run_buf[i]);
    endtask

    task automatic check_field(string what, logic [W_RGB-1:0] want, logic [W_RGB-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            err_count++;
        end
    endtask

    function automatic bit byte_q_ready();
        return text_bytes.size() > 0;
    endfunction

    // predict on each accepted byte, check each accepted event word
    always @(posedge clk) begin
        byte_fire = rst_n && drv_valid && byte_bus.ready;
        if (byte_fire) begin
            console_step(drv_byte);
            bytes_taken++;
        end
        if (rst_n && evt_bus.valid && sink_ready) begin
            got_evt.kind = t_evt_kind'(evt_bus.event_kind);
            got_evt.row  = evt_bus.cell_row;
            got_evt.col  = evt_bus.cell_column;
            got_evt.cp   = evt_bus.codepoint;
            got_evt.fg   = evt_bus.cell_foreground;
            got_evt.bg   = evt_bus.cell_background;
            got_evt.last = evt_bus.last_of_run;
            if (cell_events_due.size() == 0) begin
                $display("%0t ns: unexpected event, expected none, actual %0h",
                         $time, got_evt);
                err_count++;
            end else begin
                want_evt = cell_events_due.pop_front();
                check_field("event_kind", 24'(want_evt.kind), 24'(got_evt.kind));
                check_field("cell_row", 24'(want_evt.row), 24'(got_evt.row));
                check_field("cell_column", 24'(want_evt.col), 24'(got_evt.col));
                check_field("codepoint", 24'(want_evt.cp), 24'(got_evt.cp));
                check_field("cell_foreground", want_evt.fg, got_evt.fg);
                check_field("cell_background", want_evt.bg, got_evt.bg);
                check_field("last_of_run", 24'(want_evt.last), 24'(got_evt.last));
            end
        end
    end

    // byte driver: hold until accepted, then advance or idle
    always @(negedge clk) begin
        if (!drv_valid || byte_fire) begin
            if (byte_q_ready() && (no_idle || $urandom_range(0, 99) >= 20)) begin
                drv_valid <= 1'b1;
                drv_byte  <= text_bytes.pop_front();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // event sink
    always @(negedge clk) begin
        if (sink_hold)
            sink_ready <= 1'b0;
        else if (no_idle)
            sink_ready <= 1'b1;
        else
            sink_ready <= ($urandom_range(0, 99) >= 20);
    end

    always begin
        @(sink_stall_go);
        sink_hold = 1'b1;
        repeat (80) @(posedge clk);
        sink_hold = 1'b0;
    end

    task automatic write_reg(t_cfg_idx idx, logic [W_RGB-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            CFG_COLUMNS: grid_cols = val[W_CCNT-1:0];
            CFG_ROWS:    grid_rows = val[W_RCNT-1:0];
            CFG_FG:      ink_fg    = val;
            CFG_BG:      ink_bg    = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_grid(int cols, int rows, logic [W_RGB-1:0] fg, logic [W_RGB-1:0] bg);
        write_reg(CFG_COLUMNS, W_RGB'(cols));
        write_reg(CFG_ROWS, W_RGB'(rows));
        write_reg(CFG_FG, fg);
        write_reg(CFG_BG, bg);
    endtask

    task automatic queue_byte(logic [W_BYTE-1:0] b);
        text_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_cont();
        queue_byte(8'h80 | W_BYTE'($urandom_range(0, 63)));
    endtask

    task automatic queue_lead(int len);
        case (len)
            1:       queue_byte(8'hc0 | W_BYTE'($urandom_range(0, 31)));
            2:       queue_byte(8'he0 | W_BYTE'($urandom_range(0, 15)));
            default: queue_byte(8'hf0 | W_BYTE'($urandom_range(0, 7)));
        endcase
    endtask

    task automatic queue_random_text(int n);
        int start;
        int r;
        int len;
        logic [W_BYTE-1:0] b;
        start = bytes_queued;
        while (bytes_queued - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                queue_byte(W_BYTE'($urandom_range(32, 126)));
            end else if (r < 40) begin
                case ($urandom_range(0, 5))
                    0:       queue_byte(B_LF);
                    1:       queue_byte(B_CR);
                    2:       queue_byte(B_BS);
                    3:       queue_byte(B_TAB);
                    4:       queue_byte(W_BYTE'($urandom_range(0, 31)));
                    default: queue_byte(B_DEL);
                endcase
            end else if (r < 80) begin
                len = (r < 55) ? 1 : (r < 68) ? 2 : 3;
                queue_lead(len);
                repeat (len) queue_cont();
            end else if (r < 90) begin
                len = $urandom_range(1, 3);
                queue_lead(len);
                repeat ($urandom_range(0, len - 1)) queue_cont();
                b = W_BYTE'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                queue_byte(b);
            end else begin
                queue_byte(W_BYTE'($urandom));
            end
        end
    endtask

    // wait until every byte is taken and every event has arrived, then settle
    task automatic drain();
        while (bytes_taken != bytes_queued || cell_events_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        grid_cols = COLUMNS_RST;
        grid_rows = ROWS_RST;
        ink_fg    = FG_RST;
        ink_bg    = BG_RST;
        cur_col   = '0;
        cur_row   = '0;
        acc_cp    = '0;
        cont_left = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // defaults first, then a tiny grid for wrap, scroll and tab clamp
        queue_byte(8'h41);
        queue_byte(B_LF);
        drain();
        set_grid(4, 2, 24'h000000, 24'hFFFFFF);
        queue_byte(8'h41);
        queue_byte(8'h7e);
        queue_byte(B_SPACE);
        queue_byte(B_TAB);
        queue_byte(8'h42);
        queue_byte(8'hc3);
        queue_byte(8'ha9);
        queue_byte(B_LF);
        queue_byte(8'hff);
        queue_byte(8'h80);
        queue_byte(8'hf8);
        queue_byte(8'he2);
        queue_byte(8'h82);
        queue_byte(8'hac);
        queue_byte(8'hf4);
        queue_byte(8'h90);
        queue_byte(8'h80);
        queue_byte(8'h80);
        queue_byte(8'hf0);
        queue_byte(8'h9f);
        queue_byte(8'h98);
        queue_byte(8'h80);
        queue_byte(8'hc3);
        queue_byte(8'h41);
        queue_byte(B_BS);
        queue_byte(B_CR);
        queue_byte(8'h00);
        queue_byte(B_DEL);
        drain();

        set_grid(1, 1, 24'hFFFFFF, 24'h000000);
        queue_random_text(10);
        drain();

        no_idle = 1'b1;
        set_grid(5, 3, W_RGB'($urandom), W_RGB'($urandom));
        queue_random_text(30);
        drain();
        no_idle = 1'b0;

        set_grid(0, 0, W_RGB'($urandom), W_RGB'($urandom));
        queue_random_text(10);
        drain();

        set_grid(511, 255, 24'hA5A5A5, 24'h5A5A5A);
        queue_random_text(10);
        drain();

        set_grid(256, 128, W_RGB'($urandom), W_RGB'($urandom));
        queue_random_text(15);
        drain();

        // stall the sink while the sender keeps offering bytes
        set_grid(3, 2, W_RGB'($urandom), W_RGB'($urandom));
        @(posedge clk);
        -> sink_stall_go;
        queue_random_text(25);
        drain();

        set_grid(9, 4, W_RGB'($urandom), W_RGB'($urandom));
        queue_random_text(20);
        drain();

        // shrink the grid under the cursor
        set_grid(2, 1, W_RGB'($urandom), W_RGB'($urandom));
        queue_random_text(10);
        drain();

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== utf8_text_console_cursor_engine_unit.f =====
hw/rtl/utep_pkg.sv
hw/rtl/utep_if.sv
hw/rtl/utep_cfg.sv
hw/rtl/utep_step.sv
hw/rtl/utf8_text_console_cursor_engine_unit.sv
sim/tb_utf8_text_console_cursor_engine_unit.sv
